FILE: src/gpio_controller_with_pin_interrupts_defines.svh
// Assertion macros shared by the GPIO controller RTL.
// No dependencies; included by modules that carry assertions.
`ifndef GPIO_CONTROLLER_WITH_PIN_INTERRUPTS_DEFINES_SVH
`define GPIO_CONTROLLER_WITH_PIN_INTERRUPTS_DEFINES_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is held
`define GPIOIRQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// clocked check that also holds through reset
`define GPIOIRQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GPIOIRQ_ASSERT(label, clk, rst_n, prop, msg)
`define GPIOIRQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: src/gpioirq_pkg.sv
// Types and constants of the GPIO controller with pin interrupts.
// No dependencies; used by every module of the block.
package gpioirq_pkg;

    localparam int FIELD_W       = 32;
    localparam int PIN_COUNT_DEF = 32;
    localparam int IN_TDATA_W    = 264;  // 262 payload bits padded to bytes
    localparam int OUT_TDATA_W   = 192;

    // item action codes
    typedef enum logic [1:0] {
        ACT_IDLE  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2
    } action_t;

    // register map
    typedef enum logic [3:0] {
        REG_PORT     = 4'd0,
        REG_XOR      = 4'd1,
        REG_OUT_EN   = 4'd2,
        REG_IN_EN    = 4'd3,
        REG_FUNC_EN  = 4'd4,
        REG_FUNC_SEL = 4'd5,
        REG_IE_HIGH  = 4'd6,
        REG_IE_LOW   = 4'd7,
        REG_IE_RISE  = 4'd8,
        REG_IE_FALL  = 4'd9,
        REG_IP_HIGH  = 4'd10,
        REG_IP_LOW   = 4'd11,
        REG_IP_RISE  = 4'd12,
        REG_IP_FALL  = 4'd13,
        REG_VALUE    = 4'd14
    } reg_idx_t;

    // software pin control registers, zero above the pin count
    typedef struct packed {
        logic [FIELD_W-1:0] port;
        logic [FIELD_W-1:0] xor_mask;
        logic [FIELD_W-1:0] out_en;
        logic [FIELD_W-1:0] in_en;
        logic [FIELD_W-1:0] func_en;
        logic [FIELD_W-1:0] func_sel;
    } pin_ctrl_t;

    // muxed pin signals
    typedef struct packed {
        logic [FIELD_W-1:0] drive;
        logic [FIELD_W-1:0] out_en;
        logic [FIELD_W-1:0] in_en;
        logic [FIELD_W-1:0] gated;
    } pin_state_t;

endpackage

FILE: src/gpioirq_pinmux.sv
// Per-pin selection between software registers and two peripheral functions.
// Depends on gpioirq_pkg.
module gpioirq_pinmux (
    input  gpioirq_pkg::pin_ctrl_t              ctrl,
    input  logic [gpioirq_pkg::FIELD_W-1:0]     pad_in,
    input  logic [gpioirq_pkg::FIELD_W-1:0]     iof0_out,
    input  logic [gpioirq_pkg::FIELD_W-1:0]     iof0_out_en,
    input  logic [gpioirq_pkg::FIELD_W-1:0]     iof0_in_en,
    input  logic [gpioirq_pkg::FIELD_W-1:0]     iof1_out,
    input  logic [gpioirq_pkg::FIELD_W-1:0]     iof1_out_en,
    input  logic [gpioirq_pkg::FIELD_W-1:0]     iof1_in_en,
    output gpioirq_pkg::pin_state_t             pins
);

    localparam int FW = gpioirq_pkg::FIELD_W;

    logic [FW-1:0] oval;
    logic [FW-1:0] oe;
    logic [FW-1:0] ie;
    logic [FW-1:0] drive;
    logic [FW-1:0] level;

    // three-way select per pin
    function automatic logic [FW-1:0] pin_sel(
        input logic [FW-1:0] en,
        input logic [FW-1:0] sel,
        input logic [FW-1:0] sw,
        input logic [FW-1:0] f0,
        input logic [FW-1:0] f1
    );
        logic [FW-1:0] fn;
        fn = (sel & f1) | (~sel & f0);
        return (en & fn) | (~en & sw);
    endfunction

    // output value, enables and the gated pin level
    always_comb begin
        oval  = pin_sel(ctrl.func_en, ctrl.func_sel, ctrl.port, iof0_out, iof1_out);
        oe    = pin_sel(ctrl.func_en, ctrl.func_sel, ctrl.out_en, iof0_out_en, iof1_out_en);
        ie    = pin_sel(ctrl.func_en, ctrl.func_sel, ctrl.in_en, iof0_in_en, iof1_in_en);
        drive = ctrl.xor_mask ^ oval;
        level = (oe & drive) | (~oe & pad_in);
        pins.drive  = drive;
        pins.out_en = oe;
        pins.in_en  = ie;
        pins.gated  = ie & level;
    end

endmodule

FILE: src/gpioirq_regs.sv
// Register file, input synchronizer and interrupt pending logic.
// Depends on gpioirq_pkg and the assertion macro header.
`include "gpio_controller_with_pin_interrupts_defines.svh"
module gpioirq_regs #(
    parameter int PIN_COUNT = gpioirq_pkg::PIN_COUNT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                item_en,
    input  logic [1:0]                          action,
    input  logic [3:0]                          reg_index,
    input  logic [gpioirq_pkg::FIELD_W-1:0]     write_data,
    input  logic [gpioirq_pkg::FIELD_W-1:0]     gated,
    output gpioirq_pkg::pin_ctrl_t              ctrl,
    output logic [gpioirq_pkg::FIELD_W-1:0]     read_data,
    output logic [gpioirq_pkg::FIELD_W-1:0]     synced_in,
    output logic [gpioirq_pkg::FIELD_W-1:0]     irq_lines
);

    localparam int FW = gpioirq_pkg::FIELD_W;
    // pins above the field width carry no state that can be seen
    localparam int PW = (PIN_COUNT < FW) ? PIN_COUNT : FW;

    logic [PW-1:0] port_reg;
    logic [PW-1:0] xor_reg;
    logic [PW-1:0] out_en_reg;
    logic [PW-1:0] in_en_reg;
    logic [PW-1:0] func_en_reg;
    logic [PW-1:0] func_sel_reg;
    logic [PW-1:0] ie_reg [4];
    logic [PW-1:0] ip_reg [4];
    logic [PW-1:0] ip_next [4];
    logic [PW-1:0] sync_reg [3];
    logic [PW-1:0] wdata;
    logic [PW-1:0] rdata;
    logic [PW-1:0] irq;
    logic          wr_en;

    assign wdata = write_data[PW-1:0];
    assign wr_en = item_en && (action == gpioirq_pkg::ACT_WRITE);

    // control registers toward the pin mux
    assign ctrl.port     = FW'(port_reg);
    assign ctrl.xor_mask = FW'(xor_reg);
    assign ctrl.out_en   = FW'(out_en_reg);
    assign ctrl.in_en    = FW'(in_en_reg);
    assign ctrl.func_en  = FW'(func_en_reg);
    assign ctrl.func_sel = FW'(func_sel_reg);

    // sticky pending conditions, replaced by a software write
    always_comb begin
        ip_next[0] = ip_reg[0] | sync_reg[2];
        ip_next[1] = ip_reg[1] | ~sync_reg[2];
        ip_next[2] = ip_reg[2] | (~sync_reg[2] & sync_reg[1]);
        ip_next[3] = ip_reg[3] | (sync_reg[2] & ~sync_reg[1]);
        if (wr_en) begin
            case (reg_index)
                gpioirq_pkg::REG_IP_HIGH: ip_next[0] = wdata;
                gpioirq_pkg::REG_IP_LOW:  ip_next[1] = wdata;
                gpioirq_pkg::REG_IP_RISE: ip_next[2] = wdata;
                gpioirq_pkg::REG_IP_FALL: ip_next[3] = wdata;
                default: ;
            endcase
        end
    end

    // interrupt lines
    always_comb begin
        irq = (ie_reg[0] & ip_reg[0]) | (ie_reg[1] & ip_reg[1])
            | (ie_reg[2] & ip_reg[2]) | (ie_reg[3] & ip_reg[3]);
    end

    // register read
    always_comb begin
        rdata = '0;
        if (action == gpioirq_pkg::ACT_READ) begin
            case (reg_index)
                gpioirq_pkg::REG_PORT:     rdata = port_reg;
                gpioirq_pkg::REG_XOR:      rdata = xor_reg;
                gpioirq_pkg::REG_OUT_EN:   rdata = out_en_reg;
                gpioirq_pkg::REG_IN_EN:    rdata = in_en_reg;
                gpioirq_pkg::REG_FUNC_EN:  rdata = func_en_reg;
                gpioirq_pkg::REG_FUNC_SEL: rdata = func_sel_reg;
                gpioirq_pkg::REG_IE_HIGH:  rdata = ie_reg[0];
                gpioirq_pkg::REG_IE_LOW:   rdata = ie_reg[1];
                gpioirq_pkg::REG_IE_RISE:  rdata = ie_reg[2];
                gpioirq_pkg::REG_IE_FALL:  rdata = ie_reg[3];
                gpioirq_pkg::REG_IP_HIGH:  rdata = ip_reg[0];
                gpioirq_pkg::REG_IP_LOW:   rdata = ip_reg[1];
                gpioirq_pkg::REG_IP_RISE:  rdata = ip_reg[2];
                gpioirq_pkg::REG_IP_FALL:  rdata = ip_reg[3];
                gpioirq_pkg::REG_VALUE:    rdata = sync_reg[2];
                default:                   rdata = '0;
            endcase
        end
    end

    assign read_data = FW'(rdata);
    assign synced_in = FW'(sync_reg[2]);
    assign irq_lines = FW'(irq);

    // state update, one step per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_reg     <= '0;
            xor_reg      <= '0;
            out_en_reg   <= '0;
            in_en_reg    <= '0;
            func_en_reg  <= '0;
            func_sel_reg <= '0;
            for (int k = 0; k < 4; k++) begin
                ie_reg[k] <= '0;
                ip_reg[k] <= '0;
            end
            for (int k = 0; k < 3; k++) begin
                sync_reg[k] <= '0;
            end
        end else if (item_en) begin
            for (int k = 0; k < 4; k++) begin
                ip_reg[k] <= ip_next[k];
            end
            sync_reg[2] <= sync_reg[1];
            sync_reg[1] <= sync_reg[0];
            sync_reg[0] <= gated[PW-1:0];
            if (wr_en) begin
                case (reg_index)
                    gpioirq_pkg::REG_PORT:     port_reg     <= wdata;
                    gpioirq_pkg::REG_XOR:      xor_reg      <= wdata;
                    gpioirq_pkg::REG_OUT_EN:   out_en_reg   <= wdata;
                    gpioirq_pkg::REG_IN_EN:    in_en_reg    <= wdata;
                    gpioirq_pkg::REG_FUNC_EN:  func_en_reg  <= wdata;
                    gpioirq_pkg::REG_FUNC_SEL: func_sel_reg <= wdata;
                    gpioirq_pkg::REG_IE_HIGH:  ie_reg[0]    <= wdata;
                    gpioirq_pkg::REG_IE_LOW:   ie_reg[1]    <= wdata;
                    gpioirq_pkg::REG_IE_RISE:  ie_reg[2]    <= wdata;
                    gpioirq_pkg::REG_IE_FALL:  ie_reg[3]    <= wdata;
                    default: ;
                endcase
            end
        end
    end

    // a write to the high pending register lands as written
    `GPIOIRQ_ASSERT(a_ip_write, aclk, aresetn,
        wr_en && (reg_index == gpioirq_pkg::REG_IP_HIGH) |=> ip_reg[0] == $past(wdata),
        "high pending register does not hold the written value")
    // the synchronizer shifts on every item
    `GPIOIRQ_ASSERT(a_sync_shift, aclk, aresetn,
        item_en |=> sync_reg[2] == $past(sync_reg[1]) && sync_reg[1] == $past(sync_reg[0]),
        "synchronizer stages did not shift")
    // no item, no change to pending or synchronizer state
    `GPIOIRQ_ASSERT(a_hold_idle, aclk, aresetn,
        !item_en |=> ip_reg[1] == $past(ip_reg[1]) && sync_reg[0] == $past(sync_reg[0]),
        "state moved without an item")

endmodule

FILE: src/gpioirq_outbuf.sv
// Result register with a skid stage between the two stream sides.
// Depends on gpioirq_pkg and the assertion macro header.
`include "gpio_controller_with_pin_interrupts_defines.svh"
module gpioirq_outbuf #(
    parameter int DATA_W = gpioirq_pkg::OUT_TDATA_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] skid_data_reg;
    logic              in_fire;
    logic              out_take;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_take  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // control: result register first, skid only when it is held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_fire) begin
            if (out_valid_reg && !out_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (in_fire) begin
            if (out_valid_reg && !out_ready) begin
                skid_data_reg <= in_data;
            end else begin
                out_data_reg <= in_data;
            end
        end
    end

    // skid only fills behind a held result
    `GPIOIRQ_ASSERT_ALWAYS(a_skid_behind_out, aclk,
        !aresetn || !skid_valid_reg || out_valid_reg,
        "skid stage full while result register empty")
    // an item taken into an empty buffer shows at the output
    `GPIOIRQ_ASSERT(a_fill_shows, aclk, aresetn,
        in_fire && !out_valid_reg |=> out_valid_reg,
        "accepted item not presented")
    // a full skid stage waits until the result is taken
    `GPIOIRQ_ASSERT(a_skid_holds, aclk, aresetn,
        skid_valid_reg && !out_take |=> skid_valid_reg && $stable(skid_data_reg),
        "skid stage lost an item")

endmodule

FILE: src/gpio_controller_with_pin_interrupts.sv
// Top level of the GPIO controller with pin interrupts.
// Depends on gpioirq_pkg, gpioirq_pinmux, gpioirq_regs and gpioirq_outbuf.
//
// Usage:
//   Each item on the s_ stream is one tick of the pins: it carries an
//   optional register read or write plus the pad levels and the signals of
//   the two peripheral functions. Each item gives exactly one result on the
//   m_ stream: read data, driven pad value and enables, the synchronized pin
//   input and the interrupt lines, all as seen before the tick.
//   Each result is registered, then shown on m_tvalid. One item is accepted
//   every cycle while s_tready is high; the state update and the result logic
//   are a single registered pass through the pin mux and the register file.
//   A skid stage behind the result register keeps s_tready high for one
//   more item while m_tready is low; with both stages full s_tready drops
//   until a result is taken. Nothing is lost or repeated under stalls.
//   Pin state only advances on accepted items, so the synchronizer counts
//   items rather than clock cycles.
//   aresetn (synchronous, active low) clears all registers, the pending
//   bits and the synchronizer, and empties the result buffer.
module gpio_controller_with_pin_interrupts #(
    parameter int PIN_COUNT = gpioirq_pkg::PIN_COUNT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // action, reg_index, write_data, pad_in, iof0_out, iof0_out_en,
    // iof0_in_en, iof1_out, iof1_out_en, iof1_in_en
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gpioirq_pkg::IN_TDATA_W-1:0]  s_tdata,
    // read_data, pad_out, pad_out_en, pad_in_en, synced_in, irq_lines
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gpioirq_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int FW = gpioirq_pkg::FIELD_W;

    logic [1:0]                          action;
    logic [3:0]                          reg_index;
    logic [FW-1:0]                       write_data;
    logic [FW-1:0]                       pad_in;
    logic [FW-1:0]                       iof0_out;
    logic [FW-1:0]                       iof0_out_en;
    logic [FW-1:0]                       iof0_in_en;
    logic [FW-1:0]                       iof1_out;
    logic [FW-1:0]                       iof1_out_en;
    logic [FW-1:0]                       iof1_in_en;
    logic                                item_en;
    gpioirq_pkg::pin_ctrl_t              ctrl;
    gpioirq_pkg::pin_state_t             pins;
    logic [FW-1:0]                       read_data;
    logic [FW-1:0]                       synced_in;
    logic [FW-1:0]                       irq_lines;
    logic [gpioirq_pkg::OUT_TDATA_W-1:0] result;

    // unpack the input item
    assign action      = s_tdata[1:0];
    assign reg_index   = s_tdata[5:2];
    assign write_data  = s_tdata[37:6];
    assign pad_in      = s_tdata[69:38];
    assign iof0_out    = s_tdata[101:70];
    assign iof0_out_en = s_tdata[133:102];
    assign iof0_in_en  = s_tdata[165:134];
    assign iof1_out    = s_tdata[197:166];
    assign iof1_out_en = s_tdata[229:198];
    assign iof1_in_en  = s_tdata[261:230];

    assign item_en = s_tvalid && s_tready;

    gpioirq_pinmux u_pinmux (
        .ctrl        (ctrl),
        .pad_in      (pad_in),
        .iof0_out    (iof0_out),
        .iof0_out_en (iof0_out_en),
        .iof0_in_en  (iof0_in_en),
        .iof1_out    (iof1_out),
        .iof1_out_en (iof1_out_en),
        .iof1_in_en  (iof1_in_en),
        .pins        (pins)
    );

    gpioirq_regs #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_en    (item_en),
        .action     (action),
        .reg_index  (reg_index),
        .write_data (write_data),
        .gated      (pins.gated),
        .ctrl       (ctrl),
        .read_data  (read_data),
        .synced_in  (synced_in),
        .irq_lines  (irq_lines)
    );

    // pack the result item
    assign result = {irq_lines, synced_in, pins.in_en, pins.out_en, pins.drive, read_data};

    gpioirq_outbuf #(
        .DATA_W (gpioirq_pkg::OUT_TDATA_W)
    ) u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
